@@ src/lru_key_value_cache_unit_assert.svh @@
// assertion macros for the lru key value cache
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// same-cycle implication
`define LKV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lru_kv_pkg.sv @@
// shared types and constants for the lru key value cache
`default_nettype none

package lru_kv_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
        logic [KEY_W-1:0]          recent_key;
        logic                      recent_valid;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic update;
        logic miss;
    } t_rank_cmd;

endpackage

`default_nettype wire

@@ src/lru_kv_ram.sv @@
// generic single port ram with registered read
`default_nettype none

module lru_kv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/lru_kv_rank.sv @@
// entry valid bits and recency ranks with per-entry promote logic
`default_nettype none

module lru_kv_rank #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lru_kv_pkg::t_rank_cmd i_cmd,
    input  wire logic [IDX_W-1:0]      i_slot,
    input  wire logic [IDX_W-1:0]      i_old_rank,
    input  wire logic [IDX_W-1:0]      i_rd_idx,
    output logic                       o_valid,
    output logic [IDX_W-1:0]           o_rank
);

    import lru_kv_pkg::*;

    logic             r_valid [DEPTH];
    logic [IDX_W-1:0] r_rank  [DEPTH];
    logic             n_valid [DEPTH];
    logic [IDX_W-1:0] n_rank  [DEPTH];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (i_cmd.clear) begin
                n_valid[i] = 1'b0;
            end else if (i_cmd.update) begin
                if (IDX_W'(i) == i_slot) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (r_valid[i] && (i_cmd.miss || (r_rank[i] < i_old_rank))) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= n_valid[i];
                r_rank[i]  <= n_rank[i];
            end
        end
    end

    assign o_valid = r_valid[i_rd_idx];
    assign o_rank  = r_rank[i_rd_idx];

endmodule

`default_nettype wire

@@ src/lru_key_value_cache_unit.sv @@
// top level of the fully associative lru key value cache
//
// input channel i_in_valid / o_in_ready carries one command beat: insert or
// lookup of a key. output channel o_out_valid / i_out_ready carries one result
// beat per command: hit, read value, most recent key and its valid flag.
// a command walks the key ram one entry a cycle through a single key
// comparator, stopping at the first match, then updates ranks in the update
// state; a lookup hit then passes a fetch state for the value ram read. one
// command is in flight at a time; the next is taken once the result is
// registered, and the key ram scan sets how fast commands can follow.
// the output register holds a result while the receiver stalls; the next
// command is still accepted and scanned, and waits for the register to free.
// reset (synchronous, active low) empties the store and sets capacity to 16.
// a write on i_cfg_we, taken only while idle, sets capacity and empties the store.
`default_nettype none
`include "lru_key_value_cache_unit_assert.svh"

module lru_key_value_cache_unit #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire lru_kv_pkg::t_in                i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output lru_kv_pkg::t_out                    o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [lru_kv_pkg::CAP_W-1:0]   i_cfg_data
);

    import lru_kv_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    t_state                r_state, n_state;
    logic                  r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_chk, n_chk;
    logic                  r_chk_on, n_chk_on;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_old, n_old;
    logic [IDX_W-1:0]      r_free, n_free;
    logic                  r_free_ok, n_free_ok;
    logic [IDX_W-1:0]      r_lru, n_lru;
    logic [OCC_W-1:0]      r_occ, n_occ;
    logic [CAP_W-1:0]      r_cap, n_cap;
    logic [KEY_BITS-1:0]   r_rkey, n_rkey;
    logic                  r_rvalid, n_rvalid;
    logic [VALUE_W-1:0]    r_rd, n_rd;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic                  accept;
    logic                  is_ins;
    logic                  full;
    logic                  match;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      eff_cap;
    logic [OCC_W-1:0]      occ_m1;
    logic [IDX_W-1:0]      upd_slot;

    logic                  key_we;
    logic [IDX_W-1:0]      key_addr;
    logic [KEY_BITS-1:0]   key_rdata;
    logic                  val_we;
    logic [VALUE_BITS-1:0] val_rdata;

    t_rank_cmd             rank_cmd;
    logic                  ent_valid;
    logic [IDX_W-1:0]      ent_rank;

    lru_kv_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(DEPTH)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_addr (key_addr),
        .i_wdata(r_key),
        .o_rdata(key_rdata)
    );

    lru_kv_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_addr (upd_slot),
        .i_wdata(r_val),
        .o_rdata(val_rdata)
    );

    lru_kv_rank #(
        .DEPTH(DEPTH)
    ) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (rank_cmd),
        .i_slot    (upd_slot),
        .i_old_rank(r_old),
        .i_rd_idx  (r_chk),
        .o_valid   (ent_valid),
        .o_rank    (ent_rank)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_ins     = (r_cmd == CMD_INSERT);

    assign cap_ext = CMP_W'(r_cap);
    assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                     ((cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext);
    assign full    = (CMP_W'(r_occ) >= eff_cap);
    assign occ_m1  = r_occ - 1'b1;
    assign match   = r_chk_on && ent_valid && (key_rdata == r_key);

    assign upd_slot = r_hit ? r_slot : (full ? r_lru : r_free);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_on    = r_chk_on;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_old       = r_old;
        n_free      = r_free;
        n_free_ok   = r_free_ok;
        n_lru       = r_lru;
        n_occ       = r_occ;
        n_cap       = r_cap;
        n_rkey      = r_rkey;
        n_rvalid    = r_rvalid;
        n_rd        = r_rd;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        key_we      = 1'b0;
        key_addr    = r_idx;
        val_we      = 1'b0;
        rank_cmd    = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_cap          = i_cfg_data;
                    n_occ          = '0;
                    n_rvalid       = 1'b0;
                    rank_cmd.clear = 1'b1;
                end
                if (accept) begin
                    n_idx     = '0;
                    n_chk_on  = 1'b0;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                key_addr = r_idx;
                n_chk    = r_idx;
                n_chk_on = 1'b1;
                if (r_idx != IDX_W'(DEPTH - 1)) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_chk_on) begin
                    if (!ent_valid && !r_free_ok) begin
                        n_free    = r_chk;
                        n_free_ok = 1'b1;
                    end
                    if (ent_valid && (ent_rank == occ_m1[IDX_W-1:0])) begin
                        n_lru = r_chk;
                    end
                    if (match) begin
                        n_slot  = r_chk;
                        n_hit   = 1'b1;
                        n_old   = ent_rank;
                        n_state = ST_UPDATE;
                    end else if (r_chk == IDX_W'(DEPTH - 1)) begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                key_addr = upd_slot;
                n_rd     = '0;
                n_state  = ST_DONE;
                if (r_hit) begin
                    val_we          = is_ins;
                    rank_cmd.update = 1'b1;
                    n_rkey          = r_key;
                    n_rvalid        = 1'b1;
                    if (!is_ins) begin
                        n_state = ST_FETCH;
                    end
                end else if (is_ins) begin
                    key_we          = 1'b1;
                    val_we          = 1'b1;
                    rank_cmd.update = 1'b1;
                    rank_cmd.miss   = 1'b1;
                    n_rkey          = r_key;
                    n_rvalid        = 1'b1;
                    if (!full) begin
                        n_occ = r_occ + 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                n_rd    = VALUE_W'(val_rdata);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.hit          = r_hit;
                    n_out.read_value   = r_rd;
                    n_out.recent_key   = r_rvalid ? KEY_W'(r_rkey) : '0;
                    n_out.recent_valid = r_rvalid;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_on    <= 1'b0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            r_free_ok   <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_chk_on    <= n_chk_on;
            r_occ       <= n_occ;
            r_cap       <= n_cap;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
            r_free_ok   <= n_free_ok;
            r_hit       <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.command;
            r_key <= i_in.key[KEY_BITS-1:0];
            r_val <= VALUE_BITS'($unsigned(i_in.value));
        end
        r_idx  <= n_idx;
        r_chk  <= n_chk;
        r_slot <= n_slot;
        r_old  <= n_old;
        r_free <= n_free;
        r_lru  <= n_lru;
        r_rkey <= n_rkey;
        r_rd   <= n_rd;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `LKV_ASSERT_IMP(a_occ_recent, i_clk, i_rst_n, 1'b1,
        ((r_occ != '0) == r_rvalid), "occupancy and recent valid disagree")
    `LKV_ASSERT_NXT(a_accept_scan, i_clk, i_rst_n, accept,
        (r_state == ST_SCAN), "accepted command did not start a scan")
    `LKV_ASSERT_NXT(a_cfg_empty, i_clk, i_rst_n, (i_cfg_we && (r_state == ST_IDLE)),
        ((r_occ == '0) && !r_rvalid), "capacity write did not empty the store")
    `LKV_ASSERT_NXT(a_lookup_fetch, i_clk, i_rst_n, ((r_state == ST_UPDATE) && r_hit && !is_ins),
        (r_state == ST_FETCH), "lookup hit skipped the value read")

endmodule

`default_nettype wire

@@ tb/sv/lru_key_value_cache_unit_tb.sv @@
// self-checking testbench for the lru key value cache: directed and random accesses
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb;

    import lru_kv_pkg::*;

    localparam int LINES       = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLDOFF_AT  = 500;
    localparam int HOLDOFF_LEN = 400;

    typedef enum logic [1:0] {
        REQ_ACCESS,
        REQ_SET_CAPACITY,
        REQ_DRAIN
    } t_req_kind;

    typedef struct {
        t_req_kind        kind;
        t_in              beat;
        logic [CAP_W-1:0] cap;
    } t_request;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_in_valid = 1'b0;
    t_in              i_in       = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out             o_out;

    t_request queued_requests[$];
    t_out     expected_replies[$];

    logic [KEY_W-1:0]   line_key[LINES];
    logic [VALUE_W-1:0] line_value[LINES];
    bit                 line_used[LINES];
    int unsigned        line_age[LINES];
    int unsigned        lines_filled;
    logic [CAP_W-1:0]   capacity_setting;

    int  error_count  = 0;
    int  cycle_count  = 0;
    int  results_seen = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    bit  send_burst   = 1'b0;
    bit  take_burst   = 1'b0;

    lru_key_value_cache_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void empty_cache(input logic [CAP_W-1:0] cap);
        int i;
        for (i = 0; i < LINES; i++) begin
            line_key[i]   = '0;
            line_value[i] = '0;
            line_used[i]  = 1'b0;
            line_age[i]   = 0;
        end
        lines_filled     = 0;
        capacity_setting = cap;
    endfunction

    function automatic int unsigned usable_lines(input logic [CAP_W-1:0] cap);
        if (cap == 0) return 1;
        if (cap > LINES) return LINES;
        return cap;
    endfunction

    function automatic t_out cache_access(input t_in beat);
        t_out        res;
        int          i;
        int          slot;
        bit          found;
        bit          any;
        int unsigned worst;
        res   = '0;
        slot  = 0;
        found = 1'b0;
        for (i = 0; i < LINES; i++) begin
            if (!found && line_used[i] && line_key[i] == beat.key) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (beat.command == CMD_INSERT) begin
                line_value[slot] = beat.value;
            end else begin
                res.read_value = line_value[slot];
            end
            for (i = 0; i < LINES; i++) begin
                if (line_used[i] && i != slot && line_age[i] < line_age[slot]) begin
                    line_age[i]++;
                end
            end
            line_age[slot] = 0;
        end else if (beat.command == CMD_INSERT) begin
            any = 1'b0;
            if (lines_filled >= usable_lines(capacity_setting)) begin
                worst = 0;
                for (i = 0; i < LINES; i++) begin
                    if (line_used[i] && (!any || line_age[i] >= worst)) begin
                        worst = line_age[i];
                        slot  = i;
                        any   = 1'b1;
                    end
                end
                if (any) begin
                    line_used[slot] = 1'b0;
                    lines_filled--;
                end
            end else begin
                for (i = 0; i < LINES; i++) begin
                    if (!any && !line_used[i]) begin
                        slot = i;
                        any  = 1'b1;
                    end
                end
            end
            for (i = 0; i < LINES; i++) begin
                if (line_used[i]) line_age[i]++;
            end
            line_used[slot]  = 1'b1;
            line_key[slot]   = beat.key;
            line_value[slot] = beat.value;
            line_age[slot]   = 0;
            lines_filled++;
        end
        any = 1'b0;
        for (i = 0; i < LINES; i++) begin
            if (!any && line_used[i] && line_age[i] == 0) begin
                res.recent_key   = line_key[i];
                res.recent_valid = 1'b1;
                any = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_access(input logic cmd, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        t_request r;
        r.kind         = REQ_ACCESS;
        r.beat.command = cmd;
        r.beat.key     = key;
        r.beat.value   = value;
        r.cap          = '0;
        queued_requests.push_back(r);
    endtask

    task automatic queue_control(input t_req_kind kind, input logic [CAP_W-1:0] cap);
        t_request r;
        r.kind = kind;
        r.beat = '0;
        r.cap  = cap;
        queued_requests.push_back(r);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin : drive_requests
        logic valid_next;
        t_in  beat_next;
        logic we_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in       <= '0;
            i_cfg_we   <= 1'b0;
            i_cfg_data <= '0;
            gap_left = 0;
        end else begin
            valid_next = i_in_valid;
            beat_next  = i_in;
            we_next    = 1'b0;
            if (i_in_valid && o_in_ready) begin
                expected_replies.push_back(cache_access(i_in));
                valid_next = 1'b0;
            end
            if (!valid_next) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (queued_requests.size() != 0) begin
                    case (queued_requests[0].kind)
                        REQ_ACCESS: begin
                            beat_next  = queued_requests[0].beat;
                            valid_next = 1'b1;
                            void'(queued_requests.pop_front());
                            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                            gap_left = send_burst ? 0 : $urandom_range(0, 17);
                        end
                        REQ_SET_CAPACITY: begin
                            if (expected_replies.size() == 0) begin
                                we_next = 1'b1;
                                i_cfg_data <= queued_requests[0].cap;
                                empty_cache(queued_requests[0].cap);
                                void'(queued_requests.pop_front());
                            end
                        end
                        REQ_DRAIN: begin
                            if (expected_replies.size() == 0) begin
                                void'(queued_requests.pop_front());
                            end
                        end
                        default: ;
                    endcase
                end
            end
            i_in_valid <= valid_next;
            i_in       <= beat_next;
            i_cfg_we   <= we_next;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_replies
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_replies.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, actual %h",
                             $time, o_out);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("hit", want.hit, o_out.hit);
                    check_field("read_value", want.read_value, o_out.read_value);
                    check_field("recent_key", want.recent_key, o_out.recent_key);
                    check_field("recent_valid", want.recent_valid, o_out.recent_valid);
                end
                if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
                stall_left = take_burst ? 0 : $urandom_range(0, 17);
                if (results_seen == HOLDOFF_AT) stall_left = HOLDOFF_LEN;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int                 ph;
        int                 n;
        int                 pool_size;
        logic [CAP_W-1:0]   cap;
        logic [KEY_W-1:0]   key_pool[40];
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   ka;
        logic [KEY_W-1:0]   kb;
        logic [KEY_W-1:0]   kc;
        empty_cache(CAP_RESET);

        // empty store, field extremes, update hit, lookup miss
        queue_access(CMD_LOOKUP, 64'h0123_4567_89ab_cdef, 32'h0);
        queue_access(CMD_INSERT, 64'h0, 32'h8000_0000);
        queue_access(CMD_INSERT, '1, 32'h7fff_ffff);
        queue_access(CMD_LOOKUP, 64'h0, 32'h0);
        queue_access(CMD_LOOKUP, '1, 32'hffff_ffff);
        queue_access(CMD_INSERT, 64'h0, 32'h0000_0001);
        queue_access(CMD_LOOKUP, 64'h0, 32'h0);
        queue_access(CMD_LOOKUP, 64'h5, 32'h0);

        // capacity zero keeps one entry
        queue_control(REQ_SET_CAPACITY, 5'd0);
        queue_access(CMD_INSERT, 64'h1, random_value());
        queue_access(CMD_INSERT, 64'h2, random_value());
        queue_access(CMD_LOOKUP, 64'h1, random_value());
        queue_access(CMD_LOOKUP, 64'h2, random_value());

        // eviction follows recency, not insertion order
        ka = random_key();
        kb = random_key();
        kc = random_key();
        queue_control(REQ_SET_CAPACITY, 5'd2);
        queue_access(CMD_INSERT, ka, random_value());
        queue_access(CMD_INSERT, kb, random_value());
        queue_access(CMD_LOOKUP, ka, random_value());
        queue_access(CMD_INSERT, kc, random_value());
        queue_access(CMD_LOOKUP, kb, random_value());
        queue_access(CMD_LOOKUP, ka, random_value());
        queue_access(CMD_LOOKUP, kc, random_value());

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cap = 5'd16;
                1:       cap = 5'd1;
                2:       cap = 5'd31;
                3:       cap = 5'd0;
                4:       cap = 5'd2;
                5:       cap = 5'd17;
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            queue_control(REQ_SET_CAPACITY, cap);
            pool_size = usable_lines(cap) + $urandom_range(0, usable_lines(cap) + 3);
            for (n = 0; n < pool_size; n++) key_pool[n] = random_key();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && ph % 3 == 1) queue_control(REQ_DRAIN, '0);
                case ($urandom_range(0, 19))
                    0:       key = random_key();
                    1:       key = '0;
                    2:       key = '1;
                    default: key = key_pool[$urandom_range(0, pool_size - 1)];
                endcase
                queue_access($urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, key,
                             random_value());
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_requests.size() != 0 || expected_replies.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (2 * LINES + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
